[rtl/delimited_field_extract_assert.svh]
// Assertion macros for the delimited field extractor.
// Used by modules that carry concurrent checks; relies on clk_i and rst_ni in scope.
`ifndef DELIMITED_FIELD_EXTRACT_ASSERT_SVH
`define DELIMITED_FIELD_EXTRACT_ASSERT_SVH
`ifndef SYNTHESIS
`define DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFE_ASSERT(lbl, prop, msg)
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/dfe_pkg.sv]
// Shared types, constants and helpers for the delimited field extractor.
// No dependencies; the other RTL modules and interfaces refer to it by scoped names.
package dfe_pkg;

  localparam int DELIM_BYTES   = 8;   // cells in the match window, 1..8
  localparam int OFFSET_BITS   = 16;  // stream position width, 8..32
  localparam int OUT_BITS      = 16;  // width of the result offset/length fields
  localparam int LEN_BITS      = 4;
  localparam int PAT_BITS      = 64;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_SEL_BITS  = 2;

  localparam logic [REG_SEL_BITS-1:0] REG_OPEN_PATTERN  = 2'd0;
  localparam logic [REG_SEL_BITS-1:0] REG_OPEN_LENGTH   = 2'd1;
  localparam logic [REG_SEL_BITS-1:0] REG_CLOSE_PATTERN = 2'd2;
  localparam logic [REG_SEL_BITS-1:0] REG_CLOSE_LENGTH  = 2'd3;

  typedef struct packed {
    logic [PAT_BITS-1:0] open_pattern;
    logic [LEN_BITS-1:0] open_length;
    logic [PAT_BITS-1:0] close_pattern;
    logic [LEN_BITS-1:0] close_length;
  } cfg_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic open_hit;
    logic close_hit;
  } cell_hit_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[rtl/dfe_stream_if.sv]
// Valid/ready stream interfaces for the extractor's byte input and result output.
// Depends on dfe_pkg for the result field width.
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface dfe_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [dfe_pkg::OUT_BITS-1:0] value_offset;
  logic [dfe_pkg::OUT_BITS-1:0] value_length;

  modport source (output valid, found, value_offset, value_length, input ready);
  modport sink   (input valid, found, value_offset, value_length, output ready);
endinterface

[rtl/delimited_field_extract.sv]
// Delimited field extractor: top level with the cell chain and stream control.
// Depends on dfe_pkg, dfe_stream_if, dfe_cell, dfe_cfg_regs and the assert header.
//
// Usage: bytes of a stream arrive on in_i (data_byte, last), one word per
// byte. The opening delimiter is sought case-insensitively, then the closing
// delimiter from the end of the opening match on. A NUL byte ends the search.
// On the word marked last one result word leaves on out_o: found, the
// offset of the value and its length (both zero when not found); the stream
// state then clears for the next stream.
// Throughput: one byte per cycle while in_i.ready is high. Each byte is matched
// in the cycle it is taken, against a window of DELIM_BYTES cells that shift one
// byte for each nonzero byte taken in the search. The result is valid the cycle
// after the last byte is taken and sits in an output register; in_i.ready is low
// only while that register is full and out_o.ready is low, so a stalled receiver
// holds the input back for as long as a result word waits there.
// Reset: delimiters 0, lengths 1, stream state cleared, no result pending.
// Configure over APB (8-byte register stride) only while no stream is open.
`include "delimited_field_extract_assert.svh"

module delimited_field_extract (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dfe_in_if.sink                            in_i,
  dfe_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dfe_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [dfe_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [dfe_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int NB = dfe_pkg::DELIM_BYTES;
  localparam int OB = dfe_pkg::OFFSET_BITS;
  localparam int LB = dfe_pkg::LEN_BITS;

  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_CLOSE = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [OB-1:0] MAX_POS = '1;
  localparam logic [LB-1:0] BSS_MAX = '1;

  dfe_pkg::cfg_t      cfg;
  dfe_pkg::cell_ctrl_t cell_ctrl;
  dfe_pkg::cell_hit_t [NB-1:0] hit;
  logic [NB-1:0][7:0] chain;

  logic [1:0]    phase_q, phase_d;
  logic [OB-1:0] pos_q, pos_d;
  logic [OB-1:0] vstart_q, vstart_d;
  logic [LB-1:0] bss_q, bss_d;
  logic          mfound_q, mfound_d;
  logic [OB-1:0] mlen_q, mlen_d;

  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [dfe_pkg::OUT_BITS-1:0] out_off_q, out_off_d;
  logic [dfe_pkg::OUT_BITS-1:0] out_len_q, out_len_d;

  logic          accept;
  logic          active;
  logic          byte_nz;
  logic          pos_ok;
  logic [LB-1:0] bss_inc;
  logic [LB-1:0] open_n, close_n;
  logic [NB-1:0] open_use, close_use, open_bits, close_bits;
  logic          open_ok, close_ok;

  dfe_cfg_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .cfg_o    (cfg)
  );
  assign pready = 1'b1;

  // lengths above the window size act as the window size
  assign open_n  = (cfg.open_length > LB'(NB))  ? LB'(NB) : cfg.open_length;
  assign close_n = (cfg.close_length > LB'(NB)) ? LB'(NB) : cfg.close_length;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign active     = (phase_q == PH_OPEN) || (phase_q == PH_CLOSE);
  assign byte_nz    = (in_i.data_byte != 8'h00);
  assign pos_ok     = (pos_q != MAX_POS);
  assign bss_inc    = (bss_q == BSS_MAX) ? bss_q : bss_q + LB'(1);
  assign cell_ctrl.shift = accept && active && byte_nz;

  // cell j holds the byte j places back; it lines up with pattern byte n-1-j
  for (genvar j = 0; j < NB; j++) begin : g_cell
    logic [LB-1:0] open_idx, close_idx;
    logic [7:0]    open_b, close_b, cell_in;

    assign open_idx  = open_n - LB'(j) - LB'(1);
    assign close_idx = close_n - LB'(j) - LB'(1);
    assign open_b    = cfg.open_pattern[8*open_idx[2:0] +: 8];
    assign close_b   = cfg.close_pattern[8*close_idx[2:0] +: 8];
    assign open_use[j]  = (LB'(j) < open_n);
    assign close_use[j] = (LB'(j) < close_n);
    assign open_bits[j]  = hit[j].open_hit || !open_use[j];
    assign close_bits[j] = hit[j].close_hit || !close_use[j];

    if (j == 0) begin : g_head
      assign cell_in = in_i.data_byte;
    end else begin : g_body
      assign cell_in = chain[j-1];
    end

    dfe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .byte_i      (cell_in),
      .open_byte_i (open_b),
      .close_byte_i(close_b),
      .byte_o      (chain[j]),
      .hit_o       (hit[j])
    );
  end

  assign open_ok  = (open_n != '0) && (bss_inc >= open_n) && (&open_bits);
  assign close_ok = (close_n != '0) && (bss_inc >= close_n) && (&close_bits);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    vstart_d = vstart_q;
    bss_d    = bss_q;
    mfound_d = mfound_q;
    mlen_d   = mlen_q;

    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;

    if (accept) begin
      if (active) begin
        if (!byte_nz) begin
          phase_d = PH_DONE;
        end else begin
          bss_d = bss_inc;
          if (pos_ok) begin
            if (phase_q == PH_OPEN && open_ok) begin
              vstart_d = pos_q + OB'(1);
              phase_d  = PH_CLOSE;
              bss_d    = '0;
            end else if (phase_q == PH_CLOSE && close_ok) begin
              mfound_d = 1'b1;
              mlen_d   = pos_q + OB'(1) - OB'(close_n) - vstart_q;
              phase_d  = PH_DONE;
            end
          end
        end
      end
      if (pos_ok) begin
        pos_d = pos_q + OB'(1);
      end

      if (in_i.last) begin
        out_valid_d = 1'b1;
        out_found_d = mfound_d;
        out_off_d   = mfound_d ? dfe_pkg::OUT_BITS'(vstart_d) : '0;
        out_len_d   = mfound_d ? dfe_pkg::OUT_BITS'(mlen_d) : '0;
        phase_d  = PH_OPEN;
        pos_d    = '0;
        vstart_d = '0;
        bss_d    = '0;
        mfound_d = 1'b0;
        mlen_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      pos_q       <= '0;
      vstart_q    <= '0;
      bss_q       <= '0;
      mfound_q    <= 1'b0;
      mlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      vstart_q    <= vstart_d;
      bss_q       <= bss_d;
      mfound_q    <= mfound_d;
      mlen_q      <= mlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_off_q   <= out_off_d;
    out_len_q   <= out_len_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.value_offset = out_off_q;
  assign out_o.value_length = out_len_q;

  `DFE_ASSERT(a_notfound_zero,
    (out_valid_q && !out_found_q) |-> (out_off_q == '0 && out_len_q == '0),
    "miss result carries nonzero fields")
  `DFE_ASSERT(a_close_has_start, (phase_q == PH_CLOSE) |-> (vstart_q != '0),
    "seeking close without a value start")
  `DFE_ASSERT(a_stall_only_full, (!in_i.ready) |-> out_valid_q,
    "input stalled with empty output register")
  `DFE_ASSERT_NEXT(a_clear_on_last, accept && in_i.last,
    pos_q == '0 && phase_q == PH_OPEN && out_valid_q,
    "stream state not cleared after last word")

endmodule

[rtl/dfe_cell.sv]
// One stage of the match window: holds one recent byte and compares the byte
// entering it against its opening and closing delimiter bytes. Uses dfe_pkg.
module dfe_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfe_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          open_byte_i,
  input  logic [7:0]          close_byte_i,
  output logic [7:0]          byte_o,
  output dfe_pkg::cell_hit_t  hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic [7:0] byte_fold;

  assign byte_d    = ctrl_i.shift ? byte_i : byte_q;
  assign byte_fold = dfe_pkg::fold_case(byte_i);

  // compare on the incoming byte: it is what the window holds after this step
  assign hit_o.open_hit  = (byte_fold == dfe_pkg::fold_case(open_byte_i));
  assign hit_o.close_hit = (byte_fold == dfe_pkg::fold_case(close_byte_i));
  assign byte_o          = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

[rtl/dfe_cfg_regs.sv]
// APB register file holding the two delimiters and their lengths.
// Uses dfe_pkg for the register map and the cfg_t bundle.
module dfe_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [dfe_pkg::APB_ADDR_BITS-1:0] paddr_i,
  input  logic [dfe_pkg::APB_DATA_BITS-1:0] pwdata_i,
  output logic [dfe_pkg::APB_DATA_BITS-1:0] prdata_o,
  output dfe_pkg::cfg_t                     cfg_o
);

  dfe_pkg::cfg_t                     cfg_q;
  dfe_pkg::cfg_t                     cfg_d;
  logic                              wr_en;
  logic [dfe_pkg::REG_SEL_BITS-1:0]  reg_sel;

  // registers sit on 8-byte strides
  assign reg_sel = paddr_i[dfe_pkg::APB_ADDR_BITS-1:3];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        dfe_pkg::REG_OPEN_PATTERN:  cfg_d.open_pattern  = pwdata_i[dfe_pkg::PAT_BITS-1:0];
        dfe_pkg::REG_OPEN_LENGTH:   cfg_d.open_length   = pwdata_i[dfe_pkg::LEN_BITS-1:0];
        dfe_pkg::REG_CLOSE_PATTERN: cfg_d.close_pattern = pwdata_i[dfe_pkg::PAT_BITS-1:0];
        dfe_pkg::REG_CLOSE_LENGTH:  cfg_d.close_length  = pwdata_i[dfe_pkg::LEN_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      dfe_pkg::REG_OPEN_PATTERN:  prdata_o = dfe_pkg::APB_DATA_BITS'(cfg_q.open_pattern);
      dfe_pkg::REG_OPEN_LENGTH:   prdata_o = dfe_pkg::APB_DATA_BITS'(cfg_q.open_length);
      dfe_pkg::REG_CLOSE_PATTERN: prdata_o = dfe_pkg::APB_DATA_BITS'(cfg_q.close_pattern);
      dfe_pkg::REG_CLOSE_LENGTH:  prdata_o = dfe_pkg::APB_DATA_BITS'(cfg_q.close_length);
      default: prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_pattern  <= '0;
      cfg_q.open_length   <= dfe_pkg::LEN_BITS'(1);
      cfg_q.close_pattern <= '0;
      cfg_q.close_length  <= dfe_pkg::LEN_BITS'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench for delimited_field_extract: byte streams go in, the found flag, value offset
// and length that come out are checked word by word against an in-bench scan model.
// Depends on dfe_pkg and the dfe_in_if / dfe_out_if stream interfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dfe_pkg::OFFSET_BITS-1:0] POS_LIMIT = '1;

  typedef enum logic [1:0] {SEEK_OPEN, SEEK_CLOSE, SCAN_DONE} scan_phase_e;

  typedef struct packed {
    logic                         found;
    logic [dfe_pkg::OUT_BITS-1:0] value_offset;
    logic [dfe_pkg::OUT_BITS-1:0] value_length;
  } field_result_t;

  // Tracks the delimiter scan and holds the field results still owed by the block.
  class field_scoreboard;
    logic [dfe_pkg::PAT_BITS-1:0]    open_pat   = '0;
    logic [dfe_pkg::LEN_BITS-1:0]    open_len   = 4'd1;
    logic [dfe_pkg::PAT_BITS-1:0]    close_pat  = '0;
    logic [dfe_pkg::LEN_BITS-1:0]    close_len  = 4'd1;

    logic [63:0]                     window_bytes = '0;
    scan_phase_e                     phase        = SEEK_OPEN;
    logic [dfe_pkg::OFFSET_BITS-1:0] position     = '0;
    logic [dfe_pkg::OFFSET_BITS-1:0] value_start  = '0;
    logic [dfe_pkg::OFFSET_BITS-1:0] value_len    = '0;
    logic [3:0]                      since_count  = '0;
    logic                            hit          = 1'b0;

    field_result_t          expected_fields[$];
    int                     mismatches   = 0;

    function void restart();
      window_bytes = '0;
      phase        = SEEK_OPEN;
      position     = '0;
      value_start  = '0;
      value_len    = '0;
      since_count  = '0;
      hit          = 1'b0;
    endfunction

    function void set_register(logic [dfe_pkg::REG_SEL_BITS-1:0] idx, logic [63:0] v);
      case (idx)
        dfe_pkg::REG_OPEN_PATTERN:  open_pat  = v;
        dfe_pkg::REG_OPEN_LENGTH:   open_len  = v[dfe_pkg::LEN_BITS-1:0];
        dfe_pkg::REG_CLOSE_PATTERN: close_pat = v;
        dfe_pkg::REG_CLOSE_LENGTH:  close_len = v[dfe_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_len(logic [dfe_pkg::LEN_BITS-1:0] l);
      return (l > 4'd8) ? 8 : int'(l);
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // newest byte sits in byte 0, so the delimiter's first character is n-1 bytes back
    function bit window_hit(logic [dfe_pkg::PAT_BITS-1:0] pat,
                            logic [dfe_pkg::LEN_BITS-1:0] len);
      int unsigned n;
      logic [7:0]  w;
      logic [7:0]  p;
      n = clamp_len(len);
      if (n == 0 || since_count < n) return 1'b0;
      for (int k = 0; k < n; k++) begin
        w = window_bytes[8*(n-1-k) +: 8];
        p = pat[8*k +: 8];
        if (fold(w) != fold(p)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic l);
      logic [dfe_pkg::OFFSET_BITS-1:0] idx;
      field_result_t                   r;
      if (phase != SCAN_DONE) begin
        if (b == 8'h00) begin
          phase = SCAN_DONE;
        end else begin
          idx = position;
          window_bytes = {window_bytes[55:0], b};
          if (since_count != 4'd15) since_count++;
          if (idx != POS_LIMIT) begin
            if (phase == SEEK_OPEN && window_hit(open_pat, open_len)) begin
              value_start = idx + 1'b1;
              phase       = SEEK_CLOSE;
              since_count = '0;
            end else if (phase == SEEK_CLOSE && window_hit(close_pat, close_len)) begin
              hit       = 1'b1;
              value_len = idx + 1'b1 - dfe_pkg::OFFSET_BITS'(clamp_len(close_len))
                          - value_start;
              phase     = SCAN_DONE;
            end
          end
        end
      end
      if (position != POS_LIMIT) position++;
      if (l) begin
        r.found        = hit;
        r.value_offset = hit ? value_start : '0;
        r.value_length = hit ? value_len : '0;
        expected_fields.push_back(r);
        restart();
      end
    endfunction

    function void check_field(logic f, logic [dfe_pkg::OUT_BITS-1:0] off,
                              logic [dfe_pkg::OUT_BITS-1:0] len);
      field_result_t e;
      if (expected_fields.size() == 0) begin
        $display("%0t: word with none pending: found=%0b offset=%0d length=%0d",
                 $time, f, off, len);
        mismatches++;
        return;
      end
      e = expected_fields.pop_front();
      if (e.found !== f) begin
        $display("%0t: found expected %0b, got %0b", $time, e.found, f);
        mismatches++;
      end
      if (e.value_offset !== off) begin
        $display("%0t: value_offset expected %0d, got %0d", $time, e.value_offset, off);
        mismatches++;
      end
      if (e.value_length !== len) begin
        $display("%0t: value_length expected %0d, got %0d", $time, e.value_length, len);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [dfe_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [dfe_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [dfe_pkg::APB_DATA_BITS-1:0] prdata;
  logic                              pready;

  dfe_in_if  byte_bus ();
  dfe_out_if field_bus ();

  delimited_field_extract i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (byte_bus),
    .out_o   (field_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  field_scoreboard sb = new;
  logic [7:0]      stream_bytes[$];
  int              burst_left = 0;
  int              rx_cycle   = 0;
  int              rx_mode    = 0;

  always #1 clk_i = ~clk_i;

  // receiver: the stall style is redrawn at random from four modes
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       field_bus.ready <= 1'b1;
      1:       field_bus.ready <= ($urandom_range(0, 3) != 0);
      2:       field_bus.ready <= ((rx_cycle % 11) < 3);
      default: field_bus.ready <= rx_cycle[4];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && field_bus.valid && field_bus.ready) begin
      sb.check_field(field_bus.found, field_bus.value_offset, field_bus.value_length);
    end
  end

  function automatic logic [7:0] flip_case(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    if (l >= 8'h61 && l <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    int         r;
    logic [7:0] pick;
    r = $urandom_range(0, 199);
    if (r == 0) return 8'h00;
    if (r < 80) pick = flip_case(sb.open_pat[8*$urandom_range(0, 7) +: 8]);
    else if (r < 140) pick = flip_case(sb.close_pat[8*$urandom_range(0, 7) +: 8]);
    else if (r < 180) pick = flip_case(8'h61 + 8'($urandom_range(0, 7)));
    else pick = 8'($urandom_range(1, 255));
    return (pick == 8'h00) ? 8'h61 : pick;
  endfunction

  function automatic logic [63:0] random_pattern();
    logic [63:0] p;
    int          r;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(0, 39);
      if (r == 0) p[8*k +: 8] = 8'h00;
      else if (r < 4) p[8*k +: 8] = 8'($urandom_range(0, 255));
      else if (r == 4) p[8*k +: 8] = 8'hFF;
      else p[8*k +: 8] = flip_case(8'h61 + 8'($urandom_range(0, 7)));
    end
    return p;
  endfunction

  function automatic logic [3:0] random_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 4'd0;
    if (r <= 3) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic void push_delim(logic [63:0] pat, logic [3:0] len);
    int n;
    n = (len > 4'd8) ? 8 : int'(len);
    if (n == 0) n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) stream_bytes.push_back(flip_case(pat[8*k +: 8]));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
  endfunction

  // mostly prefix / open / value / close / suffix, some broken, some pure noise
  function automatic void build_random_stream();
    int kind;
    int cut;
    stream_bytes.delete();
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 24)) stream_bytes.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 6)) stream_bytes.push_back(noise_byte());
      push_delim(sb.open_pat, sb.open_len);
      repeat ($urandom_range(0, 10)) stream_bytes.push_back(noise_byte());
      push_delim(sb.close_pat, sb.close_len);
      repeat ($urandom_range(0, 4)) stream_bytes.push_back(noise_byte());
      if (kind < 5 && stream_bytes.size() > 1) begin
        cut = $urandom_range(0, stream_bytes.size() - 1);
        case (kind)
          2:       stream_bytes.delete(cut);
          3:       stream_bytes[cut] = noise_byte();
          default: repeat (stream_bytes.size() - 1 - cut) void'(stream_bytes.pop_back());
        endcase
      end
    end
    if (stream_bytes.size() == 0) stream_bytes.push_back(8'h61);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        byte_bus.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.last      <= l;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    sb.take_byte(b, l);
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    stream_bytes.delete();
    push_text(s);
    send_stream();
  endtask

  task automatic apb_write(input logic [dfe_pkg::REG_SEL_BITS-1:0] idx,
                           input logic [63:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // registers only change once every owed word has left and the block has drained
  task automatic quiesce();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_delims(input logic [63:0] op, input logic [3:0] ol,
                             input logic [63:0] cp, input logic [3:0] cl);
    apb_write(dfe_pkg::REG_OPEN_PATTERN, op);
    apb_write(dfe_pkg::REG_OPEN_LENGTH, {60'd0, ol});
    apb_write(dfe_pkg::REG_CLOSE_PATTERN, cp);
    apb_write(dfe_pkg::REG_CLOSE_LENGTH, {60'd0, cl});
  endtask

  initial begin
    int sent;
    logic [63:0] op;
    logic [63:0] cp;
    logic [3:0]  ol;
    logic [3:0]  cl;

    rst_ni             = 1'b0;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.last      = 1'b0;
    field_bus.ready    = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset delimiters are a single NUL, which no scanned byte can match
    stream_bytes = '{8'h41, 8'hFF};
    send_stream();
    stream_bytes = '{8'h00};
    send_stream();

    quiesce();
    load_delims(64'h6241, 4'd2, 64'h3B, 4'd1);
    send_text("aBxy;");
    send_text("AB;");
    stream_bytes.delete();
    push_text("ab");
    stream_bytes.push_back(8'h00);
    push_text(";");
    send_stream();
    send_text("abx");

    // NUL inside the closing delimiter
    quiesce();
    apb_write(dfe_pkg::REG_CLOSE_PATTERN, 64'h003B);
    apb_write(dfe_pkg::REG_CLOSE_LENGTH, 64'd2);
    send_text("ab;");

    quiesce();
    apb_write(dfe_pkg::REG_OPEN_LENGTH, 64'd0);
    send_text("ab;");

    // widest delimiters; close length above eight clamps to eight
    quiesce();
    load_delims('1, 4'd8, 64'h7A5A7A5A7A5A7A5A, 4'd15);
    stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_text("ZzZzZzZz");
    send_stream();

    for (int ph = 0; ph < 8; ph++) begin
      quiesce();
      op = random_pattern();
      cp = random_pattern();
      ol = random_len();
      cl = random_len();
      case (ph)
        0: begin ol = 4'd8; cl = 4'd15; end
        1: begin ol = 4'd1; cl = 4'd1; end
        2: begin op = '1; ol = 4'd9; end
        default: ;
      endcase
      load_delims(op, ol, cp, cl);
      sent = 0;
      while (sent < 250) begin
        build_random_stream();
        sent += stream_bytes.size();
        send_stream();
      end
    end

    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
